/* sv/xxtea_pkg.sv */
// Shared types, constants and control program of the XXTEA block cipher.
`timescale 1ns / 1ps
`default_nettype none

package xxtea_pkg;

	localparam int unsigned BLOCK_WORDS = 5;
	localparam int unsigned WORD_IDX_W  = $clog2(BLOCK_WORDS);
	localparam logic [31:0] TEA_DELTA   = 32'h9e3779b9;

	localparam logic CMD_ENCRYPT = 1'b0;
	localparam logic CMD_DECRYPT = 1'b1;

	typedef struct packed {
		logic        cmd;
		logic [31:0] data_0;
		logic [31:0] data_1;
		logic [31:0] data_2;
		logic [31:0] data_3;
		logic [31:0] data_4;
		logic [31:0] key_0;
		logic [31:0] key_1;
		logic [31:0] key_2;
		logic [31:0] key_3;
	} in_item_t;

	typedef struct packed {
		logic [31:0] result_0;
		logic [31:0] result_1;
		logic [31:0] result_2;
		logic [31:0] result_3;
		logic [31:0] result_4;
	} out_item_t;

	typedef enum logic [1:0] {
		STEP_IDLE = 2'd0,
		STEP_MIX  = 2'd1,
		STEP_EMIT = 2'd2
	} step_t;

	typedef enum logic [1:0] {
		COND_ALWAYS   = 2'd0,
		COND_IN_XFER  = 2'd1,
		COND_MIX_DONE = 2'd2,
		COND_OUT_FREE = 2'd3
	} cond_t;

	// One control word: datapath strobes, then the jump taken when cond holds
	typedef struct packed {
		logic  in_rdy;
		logic  load;
		logic  mix;
		logic  emit;
		cond_t cond;
		step_t target;
	} ucode_t;

	function automatic ucode_t ucode_rom(input step_t step);
		ucode_t uc;
		uc = '{in_rdy: 1'b0, load: 1'b0, mix: 1'b0, emit: 1'b0,
			cond: COND_ALWAYS, target: STEP_IDLE};
		unique case (step)
			STEP_IDLE: begin
				uc.in_rdy = 1'b1;
				uc.load   = 1'b1;
				uc.cond   = COND_IN_XFER;
				uc.target = STEP_MIX;
			end
			STEP_MIX: begin
				uc.mix    = 1'b1;
				uc.cond   = COND_MIX_DONE;
				uc.target = STEP_EMIT;
			end
			STEP_EMIT: begin
				uc.emit   = 1'b1;
				uc.cond   = COND_OUT_FREE;
				uc.target = STEP_IDLE;
			end
			default: begin
				uc.cond   = COND_ALWAYS;
				uc.target = STEP_IDLE;
			end
		endcase
		return uc;
	endfunction

endpackage

`default_nettype wire

/* sv/xxtea_block_cipher_top.sv */
// Top level of the XXTEA block cipher: microcoded sequencer and mixing datapath.
`timescale 1ns / 1ps
`default_nettype none

// Channel  Handshake            Payload     Carries
// in       in_valid/in_ready    in_data     cmd, five block words, four key words
// out      out_valid/out_ready  out_data    five transformed block words
//
// A block is loaded in the idle step, then mixed one step per cycle through a
// single shared mix/add unit, then moved into the output register in the
// emit step once that register is free.
// Reset (arst_n low) returns the step counter to idle and drops out_valid.
// in_ready is high only in the idle step; a finished result waits in the
// output register while the next block is taken in and worked on.
module xxtea_block_cipher_top
	import xxtea_pkg::*;
#(
	parameter int unsigned ROUND_COUNT = 6
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_ready,
	input  wire in_item_t  in_data,
	output logic           out_valid,
	input  wire logic      out_ready,
	output out_item_t      out_data
);

	localparam int unsigned RND_W = (ROUND_COUNT > 1) ? $clog2(ROUND_COUNT) : 1;
	localparam logic [RND_W-1:0] LAST_RND = RND_W'(ROUND_COUNT - 1);
	localparam logic [WORD_IDX_W-1:0] LAST_WORD = WORD_IDX_W'(BLOCK_WORDS - 1);
	// Decryption starts from ROUND_COUNT * delta, modulo 2^32
	localparam logic [31:0] DEC_SUM0 = 32'(64'(ROUND_COUNT) * 64'(TEA_DELTA));

	step_t                 step_q, step_next;
	ucode_t                uc;
	logic                  cond_ok;

	logic                  dir_q;
	logic [31:0]           sum_q;
	logic [WORD_IDX_W-1:0] p_q;
	logic [RND_W-1:0]      rnd_q;
	logic [31:0]           w_q [BLOCK_WORDS];
	logic [31:0]           k_q [4];

	logic                  last_word, mix_done;
	logic [31:0]           cur_w, y_w, z_w, mx, a_t, b_t, new_w;
	logic [1:0]            e_idx, k_idx;

	out_item_t             out_data_q;
	logic                  out_valid_q;
	logic                  out_free;

	// Sequencer: fetch the control word for the current step
	always_comb begin
		uc = ucode_rom(step_q);
	end

	assign out_free  = !out_valid_q || out_ready;
	assign last_word = (dir_q == CMD_ENCRYPT) ? (p_q == LAST_WORD) : (p_q == '0);
	assign mix_done  = last_word && (rnd_q == LAST_RND);

	always_comb begin
		case (uc.cond)
			COND_ALWAYS:   cond_ok = 1'b1;
			COND_IN_XFER:  cond_ok = in_valid;
			COND_MIX_DONE: cond_ok = mix_done;
			COND_OUT_FREE: cond_ok = out_free;
			default:       cond_ok = 1'b0;
		endcase
	end

	// Next step: jump when the condition holds, else hold
	always_comb begin
		step_next = cond_ok ? uc.target : step_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= STEP_IDLE;
		end else begin
			step_q <= step_next;
		end
	end

	assign in_ready = uc.in_rdy;

	// Mixing datapath. Words rotate through w_q so the word being updated and
	// its neighbors always sit at fixed positions.
	always_comb begin
		if (dir_q == CMD_ENCRYPT) begin
			cur_w = w_q[0];
			y_w   = w_q[1];
			z_w   = w_q[BLOCK_WORDS-1];
		end else begin
			cur_w = w_q[BLOCK_WORDS-1];
			y_w   = w_q[0];
			z_w   = w_q[BLOCK_WORDS-2];
		end
	end

	assign e_idx = sum_q[3:2];
	assign k_idx = 2'(p_q) ^ e_idx;
	assign a_t   = ((z_w >> 5) ^ (y_w << 2)) + ((y_w >> 3) ^ (z_w << 4));
	assign b_t   = (sum_q ^ y_w) + (k_q[k_idx] ^ z_w);
	assign mx    = a_t ^ b_t;
	assign new_w = (dir_q == CMD_ENCRYPT) ? (cur_w + mx) : (cur_w - mx);

	// Working registers: load on input transfer, advance on each mix step
	always_ff @(posedge clk) begin
		if (uc.load && in_valid) begin
			dir_q  <= in_data.cmd;
			w_q[0] <= in_data.data_0;
			w_q[1] <= in_data.data_1;
			w_q[2] <= in_data.data_2;
			w_q[3] <= in_data.data_3;
			w_q[4] <= in_data.data_4;
			k_q[0] <= in_data.key_0;
			k_q[1] <= in_data.key_1;
			k_q[2] <= in_data.key_2;
			k_q[3] <= in_data.key_3;
			sum_q  <= (in_data.cmd == CMD_ENCRYPT) ? TEA_DELTA : DEC_SUM0;
			p_q    <= (in_data.cmd == CMD_ENCRYPT) ? '0 : LAST_WORD;
			rnd_q  <= '0;
		end else if (uc.mix) begin
			if (dir_q == CMD_ENCRYPT) begin
				for (int i = 0; i < BLOCK_WORDS - 1; i++) begin
					w_q[i] <= w_q[i+1];
				end
				w_q[BLOCK_WORDS-1] <= new_w;
			end else begin
				for (int i = 1; i < BLOCK_WORDS; i++) begin
					w_q[i] <= w_q[i-1];
				end
				w_q[0] <= new_w;
			end
			if (last_word) begin
				// Close the round: step the sum and restart the word index
				sum_q <= (dir_q == CMD_ENCRYPT) ? (sum_q + TEA_DELTA) : (sum_q - TEA_DELTA);
				p_q   <= (dir_q == CMD_ENCRYPT) ? '0 : LAST_WORD;
				rnd_q <= rnd_q + RND_W'(1);
			end else begin
				p_q <= (dir_q == CMD_ENCRYPT) ? (p_q + WORD_IDX_W'(1))
					: (p_q - WORD_IDX_W'(1));
			end
		end
	end

	// Output register: hold the result until its transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (uc.emit && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (uc.emit && out_free) begin
			out_data_q.result_0 <= w_q[0];
			out_data_q.result_1 <= w_q[1];
			out_data_q.result_2 <= w_q[2];
			out_data_q.result_3 <= w_q[3];
			out_data_q.result_4 <= w_q[4];
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

`default_nettype wire

/* sim/tb_xxtea_block_cipher_top.sv */
// Self-checking testbench: random and directed XXTEA blocks checked against a local cipher model.
`timescale 1ns / 1ps

module tb_xxtea_block_cipher_top;
	import xxtea_pkg::*;

	// Rounds fixed for this build; the block gets the same value
	localparam int unsigned CIPHER_ROUNDS = 6;
	// Run length: directed blocks, then random blocks
	localparam int RANDOM_BLOCKS = 1200;
	// Cycles with no transfer at all before the run is declared hung
	localparam int HANG_LIMIT = 3000;
	// Clock edges to let go by at the end, after the last result is out
	localparam int TAIL_CYCLES = 40;
	// Receiver back-pressure window that fills the block up
	localparam int LONG_HOLD = 400;
	// Idle bursts stop this many transfers before the end
	localparam int QUIET_TAIL = 150;

	// One queued block; drain_first holds it back until all results are in
	typedef struct {
		in_item_t blk;
		bit       drain_first;
	} send_t;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      in_valid = 1'b0;
	logic      in_ready;
	in_item_t  in_data = '0;
	logic      out_valid;
	logic      out_ready = 1'b0;
	out_item_t out_data;

	send_t     send_q[$];       // blocks waiting to be offered
	out_item_t cipher_q[$];     // predicted results, oldest first
	int        total_items = 0;
	int        in_count;        // blocks taken by the block
	int        out_count;       // results taken from the block
	int        mismatch_cnt = 0;
	int        in_gap = 0;
	int        out_gap = 0;
	int        hold_left = 0;
	bit        long_hold_done = 1'b0;
	int        quiet_cycles = 0;

	xxtea_block_cipher_top #(
		.ROUND_COUNT(CIPHER_ROUNDS)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Cipher model
	// ------------------------------------------------------------------

	// One XXTEA mixing term; kw is the key word already chosen by p and e
	function automatic logic [31:0] tea_mix(logic [31:0] y, logic [31:0] z,
			logic [31:0] sum, logic [31:0] kw);
		logic [31:0] a;
		logic [31:0] b;
		a = ((z >> 5) ^ (y << 2)) + ((y >> 3) ^ (z << 4));
		b = (sum ^ y) + (kw ^ z);
		return a ^ b;
	endfunction

	// Encrypt or decrypt one block in place, fixed round count, no state kept
	function automatic out_item_t xxtea_transform(in_item_t blk);
		logic [31:0] w [BLOCK_WORDS];
		logic [31:0] k [4];
		logic [31:0] sum;
		logic [31:0] y;
		logic [31:0] z;
		logic [1:0]  e;
		logic [1:0]  ki;
		out_item_t   res;
		w[0] = blk.data_0;
		w[1] = blk.data_1;
		w[2] = blk.data_2;
		w[3] = blk.data_3;
		w[4] = blk.data_4;
		k[0] = blk.key_0;
		k[1] = blk.key_1;
		k[2] = blk.key_2;
		k[3] = blk.key_3;
		if (blk.cmd == CMD_ENCRYPT) begin
			// Forward pass: sum grows by delta before each round
			sum = '0;
			z = w[BLOCK_WORDS-1];
			for (int r = 0; r < CIPHER_ROUNDS; r++) begin
				sum = sum + TEA_DELTA;
				e = sum[3:2];
				for (int p = 0; p < BLOCK_WORDS; p++) begin
					y = w[(p + 1) % BLOCK_WORDS];
					ki = 2'(p) ^ e;
					w[p] = w[p] + tea_mix(y, z, sum, k[ki]);
					z = w[p];
				end
			end
		end else begin
			// Reverse pass: sum starts at rounds * delta, wrapped to 32 bits
			sum = 32'(CIPHER_ROUNDS * TEA_DELTA);
			y = w[0];
			for (int r = 0; r < CIPHER_ROUNDS; r++) begin
				e = sum[3:2];
				for (int p = BLOCK_WORDS - 1; p >= 0; p--) begin
					z = w[(p + BLOCK_WORDS - 1) % BLOCK_WORDS];
					ki = 2'(p) ^ e;
					w[p] = w[p] - tea_mix(y, z, sum, k[ki]);
					y = w[p];
				end
				sum = sum - TEA_DELTA;
			end
		end
		res.result_0 = w[0];
		res.result_1 = w[1];
		res.result_2 = w[2];
		res.result_3 = w[3];
		res.result_4 = w[4];
		return res;
	endfunction

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------

	// Same word across the block and same word across the key
	function automatic in_item_t flat_block(logic cmd, logic [31:0] d, logic [31:0] kw);
		in_item_t b;
		b = '{cmd: cmd, data_0: d, data_1: d, data_2: d, data_3: d, data_4: d,
			key_0: kw, key_1: kw, key_2: kw, key_3: kw};
		return b;
	endfunction

	// Mostly random words, with the all-zero and all-one extremes mixed in
	function automatic logic [31:0] pick_word();
		case ($urandom_range(0, 15))
			0:       return '0;
			1:       return '1;
			default: return $urandom();
		endcase
	endfunction

	function automatic in_item_t random_block();
		in_item_t b;
		b.cmd    = $urandom_range(0, 1) ? CMD_DECRYPT : CMD_ENCRYPT;
		b.data_0 = pick_word();
		b.data_1 = pick_word();
		b.data_2 = pick_word();
		b.data_3 = pick_word();
		b.data_4 = pick_word();
		b.key_0  = pick_word();
		b.key_1  = pick_word();
		b.key_2  = pick_word();
		b.key_3  = pick_word();
		return b;
	endfunction

	// Opposite command on the transformed words, same key: undoes the first block
	function automatic in_item_t inverse_of(in_item_t b);
		in_item_t  inv;
		out_item_t r;
		r = xxtea_transform(b);
		inv = b;
		inv.cmd    = (b.cmd == CMD_ENCRYPT) ? CMD_DECRYPT : CMD_ENCRYPT;
		inv.data_0 = r.result_0;
		inv.data_1 = r.result_1;
		inv.data_2 = r.result_2;
		inv.data_3 = r.result_3;
		inv.data_4 = r.result_4;
		return inv;
	endfunction

	function automatic void queue_block(in_item_t b, bit drain_first);
		send_t s;
		s.blk = b;
		s.drain_first = drain_first;
		send_q.push_back(s);
	endfunction

	// Idle bursts are allowed outside calm windows and never near the end
	function automatic bit idle_ok(int n);
		return (n < total_items - QUIET_TAIL) && ((n % 250) < 180);
	endfunction

	task automatic check_word(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %h, got %h", name, want, got);
			mismatch_cnt++;
		end
	endtask

	// ------------------------------------------------------------------
	// Sequence: build the stimulus, release reset, wait for the drain
	// ------------------------------------------------------------------
	initial begin
		in_item_t b;
		in_item_t pair_keys;

		// Directed: word extremes, both commands, patterned words
		queue_block(flat_block(CMD_ENCRYPT, '0, '0), 1'b0);
		queue_block(flat_block(CMD_DECRYPT, '0, '0), 1'b0);
		queue_block(flat_block(CMD_ENCRYPT, '1, '1), 1'b0);
		queue_block(flat_block(CMD_DECRYPT, '1, '1), 1'b0);
		queue_block(flat_block(CMD_ENCRYPT, '1, '0), 1'b0);
		queue_block(flat_block(CMD_DECRYPT, '0, '1), 1'b0);
		queue_block(flat_block(CMD_ENCRYPT, 32'h5555_5555, 32'haaaa_aaaa), 1'b0);
		queue_block(flat_block(CMD_DECRYPT, 32'haaaa_aaaa, 32'h5555_5555), 1'b0);
		queue_block(flat_block(CMD_ENCRYPT, 32'h8000_0000, 32'h0000_0001), 1'b0);
		queue_block(flat_block(CMD_DECRYPT, 32'h0000_0001, 32'h8000_0000), 1'b0);

		// Distinct key words so each key index shows up in the mix
		pair_keys = flat_block(CMD_ENCRYPT, '0, '0);
		pair_keys.data_0 = 32'h0000_0001;
		pair_keys.data_4 = 32'hffff_fffe;
		pair_keys.key_0  = 32'h0123_4567;
		pair_keys.key_1  = 32'h89ab_cdef;
		pair_keys.key_2  = 32'hfedc_ba98;
		pair_keys.key_3  = 32'h7654_3210;
		queue_block(pair_keys, 1'b0);
		queue_block(inverse_of(pair_keys), 1'b0);

		// Inverse pairs in both directions, random words
		for (int i = 0; i < 4; i++) begin
			b = random_block();
			b.cmd = (i % 2) ? CMD_DECRYPT : CMD_ENCRYPT;
			queue_block(b, 1'b0);
			queue_block(inverse_of(b), 1'b0);
		end

		// Random: mostly independent blocks, some inverse pairs.
		// First random block waits for the directed results to drain.
		for (int i = 0; i < RANDOM_BLOCKS; i++) begin
			b = random_block();
			queue_block(b, (i % 400) == 0);
			if ($urandom_range(0, 9) == 0) begin
				queue_block(inverse_of(b), 1'b0);
				i++;
			end
		end
		total_items = send_q.size();

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Advance until every block is in and every result is out
		while (in_count != total_items || out_count < in_count)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (cipher_q.size() != 0) begin
			$error("%0d results never arrived", cipher_q.size());
			mismatch_cnt++;
		end
		if (mismatch_cnt == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	// ------------------------------------------------------------------
	// Driver: offer queued blocks, hold payload until transfer
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data  <= '0;
			in_count <= 0;
			in_gap = 0;
		end else if (!in_valid || in_ready) begin
			// Transfer at this edge: predict the result, drop the block
			if (in_valid) begin
				cipher_q.push_back(xxtea_transform(in_data));
				void'(send_q.pop_front());
				in_count <= in_count + 1;
			end
			if (in_gap > 0) begin
				in_gap--;
				in_valid <= 1'b0;
			end else if (send_q.size() == 0) begin
				in_valid <= 1'b0;
			end else if (send_q[0].drain_first &&
					(in_count + (in_valid ? 1 : 0)) != out_count) begin
				// Pause until every outstanding result has come back
				in_valid <= 1'b0;
			end else if (idle_ok(in_count) && $urandom_range(0, 4) == 0) begin
				// Idle burst: in_valid drops here and stays low while in_gap counts down
				in_gap = $urandom_range(0, 6);
				in_valid <= 1'b0;
			end else begin
				in_valid <= 1'b1;
				in_data  <= send_q[0].blk;
			end
		end
	end

	// ------------------------------------------------------------------
	// Monitor: check each result transfer, drive out_ready with stalls
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		out_item_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
			out_count <= 0;
			out_gap = 0;
			hold_left = 0;
		end else begin
			if (out_valid && out_ready) begin
				out_count <= out_count + 1;
				if (cipher_q.size() == 0) begin
					$error("result with none predicted: %h", out_data);
					mismatch_cnt++;
				end else begin
					want = cipher_q.pop_front();
					check_word("result_0", want.result_0, out_data.result_0);
					check_word("result_1", want.result_1, out_data.result_1);
					check_word("result_2", want.result_2, out_data.result_2);
					check_word("result_3", want.result_3, out_data.result_3);
					check_word("result_4", want.result_4, out_data.result_4);
				end
			end

			// Once, early in the random part: hold off long enough that the
			// output register and the datapath fill and in_ready stays low
			if (!long_hold_done && out_count == 60) begin
				hold_left = LONG_HOLD;
				long_hold_done = 1'b1;
			end

			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (out_gap > 0) begin
				out_gap--;
				out_ready <= 1'b0;
			end else if (idle_ok(out_count) && $urandom_range(0, 4) == 0) begin
				out_gap = $urandom_range(0, 6);
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// ------------------------------------------------------------------
	// Watchdog: end the run if nothing moves on either channel
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= HANG_LIMIT) begin
				$display("end of test: mismatches");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

endmodule
